/* hw/rtl/hscl_pkg.sv */
// Package for the hashed sector cache lookup: sizes, field widths, codes and states.
// Used by the channel interfaces, the generic RAM users and the top level.
package hscl_pkg;

    localparam int NUM_BUFFERS  = 64;
    localparam int HASH_BUCKETS = 64;

    localparam int BUF_W   = $clog2(NUM_BUFFERS);
    localparam int LINK_W  = BUF_W + 1;
    localparam int BKT_W   = $clog2(HASH_BUCKETS);
    localparam int STEP_W  = $clog2(NUM_BUFFERS + 1);

    localparam int CMD_W      = 1;
    localparam int PAGE_W     = 31;
    localparam int VOL_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = 6;
    localparam int PPS_W      = 9;
    localparam int ENTRY_W    = PAGE_W + VOL_W;
    localparam int DIV_CNT_W  = $clog2(PAGE_W);

    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(NUM_BUFFERS);
    localparam logic [PPS_W-1:0]  PPS_RESET  = PPS_W'(8);

    localparam int unsigned REG_PPS = 0;

    localparam logic [CMD_W-1:0] CMD_READ  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT   = 2'd0,
        ST_FILL  = 2'd1,
        ST_WMISS = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_WALK,
        S_WALK_CHK,
        S_EV_RD,
        S_EV_WAIT,
        S_UL_HEAD,
        S_UL_CHK,
        S_UL_NEXT,
        S_NEW_RD,
        S_NEW_LINK,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/hscl_req_if.sv */
// Request channel of the sector cache lookup: valid/ready and the request word.
// Depends on hscl_pkg for the field widths.
interface hscl_req_if import hscl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [PAGE_W-1:0] page_number;
    logic [VOL_W-1:0]  volume_id;

    modport source (output valid, cmd, page_number, volume_id, input ready);
    modport sink (input valid, cmd, page_number, volume_id, output ready);
endinterface

/* hw/rtl/hscl_rsp_if.sv */
// Result channel of the sector cache lookup: valid/ready and the result word.
// Depends on hscl_pkg for the field widths.
interface hscl_rsp_if import hscl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    buffer_index;
    logic [PAGE_W-1:0]   sector_number;
    logic                evicted;

    modport source (output valid, status, buffer_index, sector_number, evicted, input ready);
    modport sink (input valid, status, buffer_index, sector_number, evicted, output ready);
endinterface

/* hw/rtl/hscl_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; no package needed.
module hscl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/hashed_sector_cache_lookup.sv */
// Top level of the hashed sector cache lookup: sequencer, divider and tag memories.
// Depends on hscl_pkg, hscl_req_if, hscl_rsp_if and hscl_ram.
//
// One request word is worked on at a time and each gives exactly one result word. The page
// number is first divided by pages_per_sector in a bit-serial divider, then the bucket head
// is read and the chain is walked one buffer at a time, as each step waits on the registered
// read of the link and tag memories. A read miss then fills the victim buffer; when that
// buffer holds a valid mapping, its old chain is first walked to unlink it. The result
// sits in an output register, so the next request is taken while it waits. Memories need
// no clearing pass after reset; per-entry valid bits stand for the empty state.
module hashed_sector_cache_lookup import hscl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hscl_req_if.sink           i_req,
    hscl_rsp_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [VOL_W-1:0]    r_vol, n_vol;
    logic [PAGE_W-1:0]   r_quot, n_quot;
    logic [PPS_W-1:0]    r_rem, n_rem;
    logic [PPS_W-1:0]    r_divisor, n_divisor;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [LINK_W-1:0]   r_cur, n_cur;
    logic [LINK_W-1:0]   r_prev, n_prev;
    logic [STEP_W-1:0]   r_steps, n_steps;
    logic [BKT_W-1:0]    r_hraddr;
    logic [BKT_W-1:0]    r_old_bkt, n_old_bkt;
    t_status             r_status, n_status;
    logic [BUF_W-1:0]    r_index, n_index;
    logic                r_evicted, n_evicted;
    logic [BUF_W-1:0]    r_victim, n_victim;
    logic [PPS_W-1:0]    r_pps;

    logic [NUM_BUFFERS-1:0]  r_entry_valid;
    logic [HASH_BUCKETS-1:0] r_head_set;
    logic [NUM_BUFFERS-1:0]  r_link_set;

    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [BUF_W-1:0]    r_out_index, n_out_index;
    logic [PAGE_W-1:0]   r_out_sector, n_out_sector;
    logic                r_out_evicted, n_out_evicted;

    logic                w_head_we;
    logic [BKT_W-1:0]    w_head_waddr;
    logic [LINK_W-1:0]   w_head_wdata;
    logic [BKT_W-1:0]    w_head_raddr;
    logic [LINK_W-1:0]   w_head_rdata;
    logic [LINK_W-1:0]   w_head_q;
    logic                w_link_we;
    logic [BUF_W-1:0]    w_link_waddr;
    logic [LINK_W-1:0]   w_link_wdata;
    logic [BUF_W-1:0]    w_link_raddr;
    logic [LINK_W-1:0]   w_link_rdata;
    logic [LINK_W-1:0]   w_link_q;
    logic                w_ent_we;
    logic [BUF_W-1:0]    w_ent_waddr;
    logic [ENTRY_W-1:0]  w_ent_wdata;
    logic [BUF_W-1:0]    w_ent_raddr;
    logic [ENTRY_W-1:0]  w_ent_rdata;
    logic                w_valid_set;
    logic [PPS_W:0]      w_rem_sh;
    logic                w_qbit;
    logic                w_cur_end;
    logic                w_cfg_wr;

    hscl_ram #(.WIDTH(LINK_W), .DEPTH(HASH_BUCKETS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_head_we),
        .i_waddr (w_head_waddr),
        .i_wdata (w_head_wdata),
        .i_raddr (w_head_raddr),
        .o_rdata (w_head_rdata)
    );

    hscl_ram #(.WIDTH(LINK_W), .DEPTH(NUM_BUFFERS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_raddr (w_link_raddr),
        .o_rdata (w_link_rdata)
    );

    hscl_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_BUFFERS)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (w_ent_waddr),
        .i_wdata (w_ent_wdata),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_ent_rdata)
    );

    // A head or link that has never been written reads as an empty chain.
    assign w_head_q  = r_head_set[r_hraddr] ? w_head_rdata : EMPTY_LINK;
    assign w_link_q  = r_link_set[r_cur[BUF_W-1:0]] ? w_link_rdata : EMPTY_LINK;
    assign w_cur_end = (r_cur >= EMPTY_LINK) || (r_steps == STEP_W'(NUM_BUFFERS));

    assign w_rem_sh = {r_rem, r_quot[PAGE_W-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_divisor});

    assign w_cfg_wr = psel && penable && pwrite && (paddr == PADDR_W'(4 * REG_PPS));
    assign pready   = 1'b1;
    assign prdata   = PDATA_W'(r_pps);

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.buffer_index = IDX_W'(r_out_index);
    assign o_rsp.sector_number = r_out_sector;
    assign o_rsp.evicted      = r_out_evicted;

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_vol         = r_vol;
        n_quot        = r_quot;
        n_rem         = r_rem;
        n_divisor     = r_divisor;
        n_cnt         = r_cnt;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_steps       = r_steps;
        n_old_bkt     = r_old_bkt;
        n_status      = r_status;
        n_index       = r_index;
        n_evicted     = r_evicted;
        n_victim      = r_victim;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_status  = r_out_status;
        n_out_index   = r_out_index;
        n_out_sector  = r_out_sector;
        n_out_evicted = r_out_evicted;

        w_head_we    = 1'b0;
        w_head_waddr = r_quot[BKT_W-1:0];
        w_head_wdata = LINK_W'(r_victim);
        w_head_raddr = r_quot[BKT_W-1:0];
        w_link_we    = 1'b0;
        w_link_waddr = r_victim;
        w_link_wdata = w_head_q;
        w_link_raddr = r_cur[BUF_W-1:0];
        w_ent_we     = 1'b0;
        w_ent_waddr  = r_victim;
        w_ent_wdata  = {r_quot, r_vol};
        w_ent_raddr  = r_cur[BUF_W-1:0];
        w_valid_set  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd     = i_req.cmd;
                    n_vol     = i_req.volume_id;
                    n_quot    = i_req.page_number;
                    n_rem     = '0;
                    n_cnt     = '0;
                    n_divisor = (r_pps == '0) ? PPS_W'(1) : r_pps;
                    n_evicted = 1'b0;
                    n_index   = '0;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = w_qbit ? PPS_W'(w_rem_sh - {1'b0, r_divisor}) : PPS_W'(w_rem_sh);
                n_quot = {r_quot[PAGE_W-2:0], w_qbit};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(PAGE_W - 1)) begin
                    n_state = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                n_state = S_HEAD_WAIT;
            end
            S_HEAD_WAIT: begin
                n_cur   = w_head_q;
                n_steps = '0;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (w_cur_end) begin
                    if (r_cmd == CMD_WRITE) begin
                        n_status = ST_WMISS;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_EV_RD;
                    end
                end else begin
                    n_state = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                if (r_entry_valid[r_cur[BUF_W-1:0]] && (w_ent_rdata == {r_quot, r_vol})) begin
                    n_status = ST_HIT;
                    n_index  = r_cur[BUF_W-1:0];
                    n_state  = S_DONE;
                end else begin
                    n_cur   = w_link_q;
                    n_steps = r_steps + 1'b1;
                    n_state = S_WALK;
                end
            end
            S_EV_RD: begin
                w_ent_raddr = r_victim;
                if (r_entry_valid[r_victim]) begin
                    n_state = S_EV_WAIT;
                end else begin
                    n_state = S_NEW_RD;
                end
            end
            S_EV_WAIT: begin
                n_old_bkt    = w_ent_rdata[VOL_W +: BKT_W];
                w_head_raddr = w_ent_rdata[VOL_W +: BKT_W];
                n_evicted    = 1'b1;
                n_state      = S_UL_HEAD;
            end
            S_UL_HEAD: begin
                n_cur   = w_head_q;
                n_prev  = EMPTY_LINK;
                n_steps = '0;
                n_state = S_UL_CHK;
            end
            S_UL_CHK: begin
                if (w_cur_end) begin
                    n_state = S_NEW_RD;
                end else begin
                    n_state = S_UL_NEXT;
                end
            end
            S_UL_NEXT: begin
                if (r_cur == LINK_W'(r_victim)) begin
                    if (r_prev == EMPTY_LINK) begin
                        w_head_we    = 1'b1;
                        w_head_waddr = r_old_bkt;
                        w_head_wdata = w_link_q;
                    end else begin
                        w_link_we    = 1'b1;
                        w_link_waddr = r_prev[BUF_W-1:0];
                        w_link_wdata = w_link_q;
                    end
                    n_state = S_NEW_RD;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = w_link_q;
                    n_steps = r_steps + 1'b1;
                    n_state = S_UL_CHK;
                end
            end
            S_NEW_RD: begin
                n_state = S_NEW_LINK;
            end
            S_NEW_LINK: begin
                w_link_we   = 1'b1;
                w_head_we   = 1'b1;
                w_ent_we    = 1'b1;
                w_valid_set = 1'b1;
                n_status    = ST_FILL;
                n_index     = r_victim;
                n_victim    = (r_victim == BUF_W'(NUM_BUFFERS - 1)) ? '0 : r_victim + 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_out_index   = r_index;
                    n_out_sector  = r_quot;
                    n_out_evicted = r_evicted;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_victim      <= '0;
            r_out_valid   <= 1'b0;
            r_pps         <= PPS_RESET;
            r_entry_valid <= '0;
            r_head_set    <= '0;
            r_link_set    <= '0;
        end else begin
            r_state     <= n_state;
            r_victim    <= n_victim;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                r_pps <= pwdata[PPS_W-1:0];
            end
            if (w_valid_set) begin
                r_entry_valid[r_victim] <= 1'b1;
            end
            if (w_head_we) begin
                r_head_set[w_head_waddr] <= 1'b1;
            end
            if (w_link_we) begin
                r_link_set[w_link_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_vol         <= n_vol;
        r_quot        <= n_quot;
        r_rem         <= n_rem;
        r_divisor     <= n_divisor;
        r_cnt         <= n_cnt;
        r_cur         <= n_cur;
        r_prev        <= n_prev;
        r_steps       <= n_steps;
        r_hraddr      <= w_head_raddr;
        r_old_bkt     <= n_old_bkt;
        r_status      <= n_status;
        r_index       <= n_index;
        r_evicted     <= n_evicted;
        r_out_status  <= n_out_status;
        r_out_index   <= n_out_index;
        r_out_sector  <= n_out_sector;
        r_out_evicted <= n_out_evicted;
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while another is in progress");

    a_wmiss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == STATUS_W'(ST_WMISS))) |->
        ((o_rsp.buffer_index == '0) && !o_rsp.evicted))
        else $error("write miss carries a buffer or an eviction");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == STATUS_W'(ST_HIT))) |-> !o_rsp.evicted)
        else $error("hit reported an eviction");

    a_victim_on_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_victim != $past(r_victim)) |-> ($past(r_state) == S_NEW_LINK))
        else $error("victim pointer moved outside a fill");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for hashed_sector_cache_lookup: directed rows, then random phases.
// Predicts each lookup with its own copy of the chains and tags; needs hscl_pkg and the
// request and result channel interfaces.
`timescale 1ns / 100ps

module testbench;
    import hscl_pkg::*;

    localparam int unsigned LIMIT_CYCLES    = 2_000_000;
    localparam int          DIRECTED_ROWS   = 24;
    localparam int          NUM_PHASES      = 10;
    localparam int          ITEMS_PER_PHASE = 130;
    localparam int          MAX_PRINTED     = 40;

    localparam logic [PADDR_W-1:0] PPS_ADDR = PADDR_W'(4 * REG_PPS);

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   buffer_index;
        logic [PAGE_W-1:0]  sector_number;
        logic               evicted;
    } lookup_result_t;

    typedef enum bit {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [CMD_W-1:0]   cmd;
        logic [PDATA_W-1:0] arg;
        logic [VOL_W-1:0]   vol;
        bit                 typed;
        lookup_result_t     want;
    } stim_row_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [VOL_W-1:0]  vol;
    } page_ref_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    hscl_req_if req_if ();
    hscl_rsp_if rsp_if ();

    hashed_sector_cache_lookup u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the tag side.
    logic [LINK_W-1:0] head_of   [HASH_BUCKETS];
    logic [LINK_W-1:0] next_of   [NUM_BUFFERS];
    logic [PAGE_W-1:0] sector_of [NUM_BUFFERS];
    logic [VOL_W-1:0]  volume_of [NUM_BUFFERS];
    bit                held      [NUM_BUFFERS];
    logic [BUF_W-1:0]  victim_ptr;
    logic [PPS_W-1:0]  pps_reg;

    lookup_result_t pending_results [$];
    page_ref_t      recent_refs [$];
    bit             typed_pending = 1'b0;
    lookup_result_t typed_value;
    bit             req_gaps = 1'b1;
    bit             rsp_stalls = 1'b1;
    int unsigned    hot_bkt [4];
    logic [VOL_W-1:0] vol_pool [4];

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned items_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned n_hits = 0;
    int unsigned n_fills = 0;
    int unsigned n_evictions = 0;
    int unsigned n_write_misses = 0;
    int unsigned n_settings = 1;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d result words outstanding.",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic lookup_result_t predict_lookup(input logic [CMD_W-1:0] cmd,
                                                      input logic [PAGE_W-1:0] page,
                                                      input logic [VOL_W-1:0] vol);
        lookup_result_t    res;
        int unsigned       divisor;
        logic [PAGE_W-1:0] sector;
        int unsigned       bkt;
        int unsigned       old_bkt;
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] found;
        logic [BUF_W-1:0]  vic;
        int                n;
        divisor = (pps_reg == 0) ? 1 : pps_reg;
        sector  = PAGE_W'(page / divisor);
        bkt     = sector % HASH_BUCKETS;
        found   = EMPTY_LINK;
        cur     = head_of[bkt];
        for (n = 0; n < NUM_BUFFERS && cur < NUM_BUFFERS; n++) begin
            if (held[cur[BUF_W-1:0]] && sector_of[cur[BUF_W-1:0]] == sector &&
                volume_of[cur[BUF_W-1:0]] == vol) begin
                found = cur;
                break;
            end
            cur = next_of[cur[BUF_W-1:0]];
        end
        res.sector_number = sector;
        res.buffer_index  = '0;
        res.evicted       = 1'b0;
        if (found != EMPTY_LINK) begin
            res.status       = ST_HIT;
            res.buffer_index = found[BUF_W-1:0];
        end else if (cmd == CMD_WRITE) begin
            res.status = ST_WMISS;
        end else begin
            vic        = victim_ptr;
            victim_ptr = BUF_W'((vic + 1) % NUM_BUFFERS);
            if (held[vic]) begin
                res.evicted = 1'b1;
                old_bkt     = sector_of[vic] % HASH_BUCKETS;
                cur         = head_of[old_bkt];
                prev        = EMPTY_LINK;
                for (n = 0; n < NUM_BUFFERS && cur < NUM_BUFFERS; n++) begin
                    if (cur == vic) begin
                        if (prev == EMPTY_LINK) begin
                            head_of[old_bkt] = next_of[cur[BUF_W-1:0]];
                        end else begin
                            next_of[prev[BUF_W-1:0]] = next_of[cur[BUF_W-1:0]];
                        end
                        break;
                    end
                    prev = cur;
                    cur  = next_of[cur[BUF_W-1:0]];
                end
            end
            next_of[vic]     = head_of[bkt];
            head_of[bkt]     = LINK_W'(vic);
            sector_of[vic]   = sector;
            volume_of[vic]   = vol;
            held[vic]        = 1'b1;
            res.status       = ST_FILL;
            res.buffer_index = vic;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        lookup_result_t got;
        lookup_result_t want;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got.status        = t_status'(rsp_if.status);
                got.buffer_index  = rsp_if.buffer_index;
                got.sector_number = rsp_if.sector_number;
                got.evicted       = rsp_if.evicted;
                if (pending_results.size() == 0) begin
                    report_error($sformatf("result word with none expected: status %0d buffer %0d",
                                           got.status, got.buffer_index));
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        report_error($sformatf("word %0d: status %0d, expected %0d",
                                               results_checked, got.status, want.status));
                    if (got.buffer_index !== want.buffer_index)
                        report_error($sformatf("word %0d: buffer %0d, expected %0d",
                                               results_checked, got.buffer_index,
                                               want.buffer_index));
                    if (got.sector_number !== want.sector_number)
                        report_error($sformatf("word %0d: sector %0h, expected %0h",
                                               results_checked, got.sector_number,
                                               want.sector_number));
                    if (got.evicted !== want.evicted)
                        report_error($sformatf("word %0d: evicted %0b, expected %0b",
                                               results_checked, got.evicted, want.evicted));
                    results_checked++;
                end
            end
            if (req_if.valid && req_if.ready) begin
                want = predict_lookup(req_if.cmd, req_if.page_number, req_if.volume_id);
                case (want.status)
                    ST_HIT: begin
                        n_hits++;
                    end
                    ST_FILL: begin
                        n_fills++;
                        if (want.evicted) n_evictions++;
                    end
                    default: begin
                        n_write_misses++;
                    end
                endcase
                if (typed_pending) begin
                    want          = typed_value;
                    typed_pending = 1'b0;
                end
                pending_results.push_back(want);
                items_accepted++;
            end
        end
    end

    initial begin : result_sink
        int unsigned stall;
        @(posedge i_rst_n);
        forever begin
            stall = rsp_stalls ? $urandom_range(0, 5) : 0;
            if (stall != 0) begin
                rsp_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready = 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            @(negedge i_clk);
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] page,
                                input logic [VOL_W-1:0] vol);
        int unsigned gap;
        gap = req_gaps ? $urandom_range(0, 5) : 0;
        repeat (gap) @(negedge i_clk);
        req_if.valid       = 1'b1;
        req_if.cmd         = cmd;
        req_if.page_number = page;
        req_if.volume_id   = vol;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
        req_if.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [PADDR_W-1:0] addr,
                                  input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if ((addr >> 2) == REG_PPS) pps_reg = data[PPS_W-1:0];
        n_settings++;
    endtask

    function automatic stim_row_t row_req(input logic [CMD_W-1:0] cmd,
                                          input logic [PAGE_W-1:0] page,
                                          input logic [VOL_W-1:0] vol);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_REQ;
        r.cmd   = cmd;
        r.arg   = PDATA_W'(page);
        r.vol   = vol;
        return r;
    endfunction

    function automatic stim_row_t row_chk(input logic [CMD_W-1:0] cmd,
                                          input logic [PAGE_W-1:0] page,
                                          input logic [VOL_W-1:0] vol, input t_status st,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [PAGE_W-1:0] sector, input logic ev);
        stim_row_t r;
        r                    = row_req(cmd, page, vol);
        r.typed              = 1'b1;
        r.want.status        = st;
        r.want.buffer_index  = idx;
        r.want.sector_number = sector;
        r.want.evicted       = ev;
        return r;
    endfunction

    function automatic stim_row_t row_cfg(input logic [PDATA_W-1:0] value);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.arg  = value;
        return r;
    endfunction

    // Runs with the reset divisor of 8 until the first register write.
    function automatic stim_row_t directed_row(input int n);
        case (n)
            0:  return row_chk(CMD_WRITE, 31'd0, 16'h0000, ST_WMISS, 6'd0, 31'd0, 1'b0);
            1:  return row_chk(CMD_READ, 31'd0, 16'h0000, ST_FILL, 6'd0, 31'd0, 1'b0);
            2:  return row_chk(CMD_READ, 31'd7, 16'h0000, ST_HIT, 6'd0, 31'd0, 1'b0);
            3:  return row_chk(CMD_WRITE, 31'd5, 16'h0000, ST_HIT, 6'd0, 31'd0, 1'b0);
            4:  return row_chk(CMD_READ, 31'd0, 16'h0001, ST_FILL, 6'd1, 31'd0, 1'b0);
            5:  return row_chk(CMD_READ, 31'h7FFF_FFFF, 16'hFFFF, ST_FILL, 6'd2,
                               31'h0FFF_FFFF, 1'b0);
            6:  return row_chk(CMD_WRITE, 31'h7FFF_FFFF, 16'hFFFF, ST_HIT, 6'd2,
                               31'h0FFF_FFFF, 1'b0);
            7:  return row_chk(CMD_WRITE, 31'h7FFF_FFFF, 16'hFFFE, ST_WMISS, 6'd0,
                               31'h0FFF_FFFF, 1'b0);
            8:  return row_chk(CMD_READ, 31'd512, 16'h0000, ST_FILL, 6'd3, 31'd64, 1'b0);
            9:  return row_chk(CMD_READ, 31'd0, 16'h0001, ST_HIT, 6'd1, 31'd0, 1'b0);
            10: return row_chk(CMD_READ, 31'd0, 16'h0000, ST_HIT, 6'd0, 31'd0, 1'b0);
            11: return row_chk(CMD_READ, 31'd8, 16'h0000, ST_FILL, 6'd4, 31'd1, 1'b0);
            12: return row_cfg(32'd0);
            13: return row_chk(CMD_READ, 31'd1, 16'h0000, ST_HIT, 6'd4, 31'd1, 1'b0);
            14: return row_chk(CMD_READ, 31'h7FFF_FFFF, 16'h1234, ST_FILL, 6'd5,
                               31'h7FFF_FFFF, 1'b0);
            15: return row_cfg(32'hFFFF_FF00);
            16: return row_chk(CMD_READ, 31'h7FFF_FFFF, 16'h0000, ST_FILL, 6'd6,
                               31'h007F_FFFF, 1'b0);
            17: return row_req(CMD_WRITE, 31'h5A5A_5A5A, 16'hA5A5);
            18: return row_cfg(32'd511);
            19: return row_req(CMD_READ, 31'h7FFF_FFFF, 16'h0003);
            20: return row_cfg(32'd1);
            21: return row_req(CMD_READ, 31'h2AAA_AAAA, 16'h5555);
            22: return row_req(CMD_WRITE, 31'h5555_5555, 16'hAAAA);
            default: return row_cfg(32'd8);
        endcase
    endfunction

    function automatic logic [PDATA_W-1:0] phase_divisor(input int ph);
        case (ph)
            0:       return 32'd1;
            1:       return $urandom_range(2, 16);
            2:       return 32'd256;
            3:       return 32'd0;
            4:       return $urandom_range(257, 511);
            5:       return 32'd8;
            6:       return $urandom_range(1, 256);
            7:       return 32'd3;
            8:       return $urandom_range(2, 64);
            default: return 32'd511;
        endcase
    endfunction

    // Most requests land in a few hot buckets with a few volumes or repeat a recent request, so
    // chains grow long and lookups revisit sectors; the rest are fully random words.
    task automatic pick_request(output logic [CMD_W-1:0] cmd, output logic [PAGE_W-1:0] page,
                                output logic [VOL_W-1:0] vol);
        int unsigned     roll;
        int unsigned     divisor;
        longint unsigned sector;
        longint unsigned addr;
        page_ref_t       ref_item;
        roll = $urandom_range(0, 99);
        cmd  = ($urandom_range(0, 99) < 25) ? CMD_WRITE : CMD_READ;
        if (roll < 35 && recent_refs.size() != 0) begin
            ref_item = recent_refs[$urandom_range(0, recent_refs.size() - 1)];
            page     = ref_item.page;
            vol      = ref_item.vol;
        end else if (roll < 85) begin
            divisor = (pps_reg == 0) ? 1 : pps_reg;
            if ($urandom_range(0, 9) == 0)
                sector = hot_bkt[$urandom_range(0, 3)] + 64 * longint'($urandom_range(0, 1 << 24));
            else
                sector = hot_bkt[$urandom_range(0, 3)] + 64 * $urandom_range(0, 15);
            addr = sector * divisor + $urandom_range(0, divisor - 1);
            page = (addr > 64'h7FFF_FFFF) ? PAGE_W'($urandom) : PAGE_W'(addr);
            vol  = vol_pool[$urandom_range(0, 3)];
        end else begin
            page = PAGE_W'($urandom);
            vol  = VOL_W'($urandom);
        end
        ref_item.page = page;
        ref_item.vol  = vol;
        recent_refs.push_back(ref_item);
        if (recent_refs.size() > 48) void'(recent_refs.pop_front());
    endtask

    initial begin : stimulus
        int               i;
        int               ph;
        stim_row_t        row;
        logic [CMD_W-1:0] cmd;
        logic [PAGE_W-1:0] page;
        logic [VOL_W-1:0] vol;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_if.valid       = 1'b0;
        req_if.cmd         = CMD_READ;
        req_if.page_number = '0;
        req_if.volume_id   = '0;
        rsp_if.ready       = 1'b0;
        for (i = 0; i < HASH_BUCKETS; i++) head_of[i] = EMPTY_LINK;
        for (i = 0; i < NUM_BUFFERS; i++) begin
            next_of[i]   = EMPTY_LINK;
            sector_of[i] = '0;
            volume_of[i] = '0;
            held[i]      = 1'b0;
        end
        victim_ptr = '0;
        pps_reg    = PPS_RESET;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_row(i);
            if (row.kind == ROW_CFG) begin
                wait_drained();
                write_register(PPS_ADDR, row.arg);
            end else begin
                if (row.typed) begin
                    typed_value   = row.want;
                    typed_pending = 1'b1;
                end
                send_request(row.cmd, row.arg[PAGE_W-1:0], row.vol);
            end
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            write_register(PPS_ADDR, ($urandom & ~32'h1FF) | phase_divisor(ph));
            for (i = 0; i < 4; i++) hot_bkt[i] = $urandom_range(0, HASH_BUCKETS - 1);
            vol_pool[0] = 16'h0000;
            vol_pool[1] = 16'h0001;
            vol_pool[2] = 16'hFFFF;
            vol_pool[3] = VOL_W'($urandom);
            req_gaps   = ($urandom_range(0, 3) != 0);
            rsp_stalls = ($urandom_range(0, 3) != 0);
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                pick_request(cmd, page, vol);
                send_request(cmd, page, vol);
            end
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Checked %0d result words for %0d request words across %0d divisor settings.",
                 results_checked, items_accepted, n_settings);
        $display("Hits %0d, fills %0d with %0d evictions, ignored write misses %0d.",
                 n_hits, n_fills, n_evictions, n_write_misses);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches found.", error_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/hscl_pkg.sv
hw/rtl/hscl_req_if.sv
hw/rtl/hscl_rsp_if.sv
hw/rtl/hscl_ram.sv
hw/rtl/hashed_sector_cache_lookup.sv
dv/testbench.sv
